// ----- rtl/rfoc_pkg.sv -----
`default_nettype none

package rfoc_pkg;

    // tick counter width
    localparam int TIMER_W      = 14;
    localparam int MASTER_W     = 16;
    localparam int REPEAT_W     = 4;
    localparam int CFG_DATA_W   = (TIMER_W > MASTER_W) ? TIMER_W : MASTER_W;
    localparam int CFG_INDEX_W  = 3;

    localparam int FRAME_LEN    = 48;
    localparam int POS_W        = 6;
    localparam logic [15:0] FRAME_PREFIX = 16'hAAFF;
    localparam logic [7:0]  FRAME_SUFFIX = 8'h00;

    localparam logic [MASTER_W-1:0] MASTER_CODE_RST = MASTER_W'(25105);
    localparam logic [TIMER_W-1:0]  SHORT_HIGH_RST  = TIMER_W'(295);
    localparam logic [TIMER_W-1:0]  LONG_HIGH_RST   = TIMER_W'(645);
    localparam logic [TIMER_W-1:0]  LOW_RST         = TIMER_W'(285);
    localparam logic [TIMER_W-1:0]  GAP_RST         = TIMER_W'(9500);
    localparam logic [REPEAT_W-1:0] REPEAT_RST      = REPEAT_W'(5);

    // stream word layouts
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 8;

    // highest valid group and button codes
    localparam logic [2:0] GROUP_MAX  = 3'd5;
    localparam logic [2:0] BUTTON_MAX = 3'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MASTER_CODE = 3'd0,
        REG_SHORT_HIGH  = 3'd1,
        REG_LONG_HIGH   = 3'd2,
        REG_LOW         = 3'd3,
        REG_GAP         = 3'd4,
        REG_REPEAT      = 3'd5
    } cfg_reg_t;

    // group a..f nibble codes
    localparam logic [3:0] GROUP_CODES [6] = '{4'hF, 4'hE, 4'hD, 4'hC, 4'hA, 4'h9};

    function automatic logic [3:0] group_code(input logic [2:0] grp);
        logic [3:0] code;
        code = 4'hF;
        if (grp <= GROUP_MAX)
        begin
            code = GROUP_CODES[grp];
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rf_outlet_code_pulse_encoder.sv -----
`default_nettype none

// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser: command; tdata: group, button, on
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: rf_level, busy_res; tlast: done_res
// cfg       | in  | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// one tick word in, one result word out; a word is taken every cycle while the
// output register is empty or being drained, so the sustained rate is one word per cycle
// and the result is registered as the word is taken (state and result share the same edge)
// rst_n clears the sequencer to idle and the registers to their default values
// a stall on m_axis holds the result register and drops s_axis_tready; cfg is always ready

module rf_outlet_code_pulse_encoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // [0] group_letter[0] .. [2] group_letter[2], [5:3] button_number, [6] turn_on, [7] zero
    input  wire logic [rfoc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  wire logic                              s_axis_tuser,
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] rf_level, [1] busy_res, [7:2] zero
    output      logic [rfoc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // done_res
    output      logic                              m_axis_tlast,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [rfoc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rfoc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rfoc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_GAP
    } phase_t;

    // configuration registers
    logic [MASTER_W-1:0]  master_code_reg;
    logic [TIMER_W-1:0]   short_high_reg;
    logic [TIMER_W-1:0]   long_high_reg;
    logic [TIMER_W-1:0]   low_reg;
    logic [TIMER_W-1:0]   gap_reg;
    logic [REPEAT_W-1:0]  repeat_reg;

    // sequencer state
    phase_t               phase_reg, phase_next;
    logic [FRAME_LEN-1:0] frame_reg, frame_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [REPEAT_W-1:0]  passes_reg, passes_next;
    logic [TIMER_W-1:0]   ticks_reg, ticks_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic                 level_reg, level_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic                 in_accept;
    logic                 cfg_write;
    logic [2:0]           grp;
    logic [2:0]           btn;
    logic                 turn_on;
    logic                 start;
    logic [3:0]           btn_code;
    logic [FRAME_LEN-1:0] frame_new;
    logic [FRAME_LEN-1:0] frame_cur;
    phase_t               phase_cur;
    logic [TIMER_W-1:0]   ticks_cur;
    logic [POS_W-1:0]     pos_cur;
    logic [POS_W-1:0]     pos_inc;
    logic [REPEAT_W-1:0]  passes_cur;
    logic [REPEAT_W-1:0]  passes_inc;
    logic [REPEAT_W-1:0]  reps;
    logic [TIMER_W-1:0]   ticks_dec;
    logic                 first_bit;
    logic                 next_bit;
    logic [TIMER_W-1:0]   short_eff;
    logic [TIMER_W-1:0]   long_eff;
    logic [TIMER_W-1:0]   low_eff;
    logic [TIMER_W-1:0]   gap_eff;

    // a zero duration counts as one tick
    function automatic logic [TIMER_W-1:0] at_least_one(input logic [TIMER_W-1:0] v);
        return (v == '0) ? TIMER_W'(1) : v;
    endfunction

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_write     = cfg_valid && cfg_ready;

    assign grp     = s_axis_tdata[2:0];
    assign btn     = s_axis_tdata[5:3];
    assign turn_on = s_axis_tdata[6];

    assign short_eff = at_least_one(short_high_reg);
    assign long_eff  = at_least_one(long_high_reg);
    assign low_eff   = at_least_one(low_reg);
    assign gap_eff   = at_least_one(gap_reg);
    assign reps      = (repeat_reg == '0) ? REPEAT_W'(1) : repeat_reg;

    // button code is 14 - 2*button, one less for the off code
    assign btn_code  = 4'd14 - {btn, 1'b0} - {3'b000, ~turn_on};
    assign frame_new = {FRAME_PREFIX, master_code_reg, group_code(grp), btn_code, FRAME_SUFFIX};

    assign start = s_axis_tuser && (phase_reg == PH_IDLE)
                   && (grp <= GROUP_MAX) && (btn <= BUTTON_MAX);

    always_comb
    begin
        // state as seen after an optional frame start on this tick
        frame_cur  = start ? frame_new : frame_reg;
        phase_cur  = start ? PH_HIGH : phase_reg;
        pos_cur    = start ? '0 : pos_reg;
        passes_cur = start ? '0 : passes_reg;
        first_bit  = frame_cur[FRAME_LEN-1];
        ticks_cur  = start ? (first_bit ? short_eff : long_eff) : ticks_reg;

        pos_inc    = pos_cur + POS_W'(1);
        passes_inc = passes_cur + REPEAT_W'(1);
        next_bit   = frame_cur[POS_W'(FRAME_LEN - 1) - pos_inc];
        ticks_dec  = ticks_cur - TIMER_W'(1);

        frame_next  = frame_cur;
        phase_next  = phase_cur;
        pos_next    = pos_cur;
        passes_next = passes_cur;
        ticks_next  = ticks_cur;
        level_next  = 1'b0;
        busy_next   = 1'b0;
        done_next   = 1'b0;

        if (phase_cur != PH_IDLE)
        begin
            busy_next  = 1'b1;
            level_next = (phase_cur == PH_HIGH);
            ticks_next = ticks_dec;
            if (ticks_dec == '0)
            begin
                case (phase_cur)
                    PH_HIGH:
                    begin
                        phase_next = PH_LOW;
                        ticks_next = low_eff;
                    end
                    PH_LOW:
                    begin
                        if (pos_cur >= POS_W'(FRAME_LEN - 1))
                        begin
                            phase_next = PH_GAP;
                            ticks_next = gap_eff;
                        end
                        else
                        begin
                            pos_next   = pos_inc;
                            phase_next = PH_HIGH;
                            ticks_next = next_bit ? short_eff : long_eff;
                        end
                    end
                    PH_GAP:
                    begin
                        passes_next = passes_inc;
                        pos_next    = '0;
                        // counter wrap also ends the run
                        if (passes_inc >= reps || passes_inc == '0)
                        begin
                            phase_next = PH_IDLE;
                            ticks_next = '0;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_HIGH;
                            ticks_next = first_bit ? short_eff : long_eff;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            frame_reg     <= '0;
            pos_reg       <= '0;
            passes_reg    <= '0;
            ticks_reg     <= '0;
            out_valid_reg <= 1'b0;
            level_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                phase_reg  <= phase_next;
                frame_reg  <= frame_next;
                pos_reg    <= pos_next;
                passes_reg <= passes_next;
                ticks_reg  <= ticks_next;
                level_reg  <= level_next;
                busy_reg   <= busy_next;
                done_reg   <= done_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_code_reg <= MASTER_CODE_RST;
            short_high_reg  <= SHORT_HIGH_RST;
            long_high_reg   <= LONG_HIGH_RST;
            low_reg         <= LOW_RST;
            gap_reg         <= GAP_RST;
            repeat_reg      <= REPEAT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MASTER_CODE: master_code_reg <= cfg_data[MASTER_W-1:0];
                REG_SHORT_HIGH:  short_high_reg  <= cfg_data[TIMER_W-1:0];
                REG_LONG_HIGH:   long_high_reg   <= cfg_data[TIMER_W-1:0];
                REG_LOW:         low_reg         <= cfg_data[TIMER_W-1:0];
                REG_GAP:         gap_reg         <= cfg_data[TIMER_W-1:0];
                REG_REPEAT:      repeat_reg      <= cfg_data[REPEAT_W-1:0];
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - 2)'(0), busy_reg, level_reg};
    assign m_axis_tlast  = done_reg;

endmodule

`default_nettype wire

// ----- rtl/rfoc_checker.sv -----
`default_nettype none

module rfoc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [rfoc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire logic                              m_axis_tlast
);
    import rfoc_pkg::*;

    // sequence end only while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1])
        else $error("done without busy");

    // line high only while busy
    a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("line high while idle");

    // empty result register always takes a word
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // padding bits of the result word stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:2] == '0))
        else $error("result padding not zero");

endmodule

bind rf_outlet_code_pulse_encoder rfoc_checker u_rfoc_checker (.*);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

// frame layout constants for the predictor
localparam logic [15:0] FRAME_HEAD  = 16'hAAFF;
localparam logic [7:0]  FRAME_TAIL  = 8'h00;
localparam int          FRAME_BITS  = 48;
localparam logic [2:0]  GROUP_LAST  = 3'd5;
localparam logic [2:0]  BUTTON_LAST = 3'd4;

// register indexes beyond the map, written to show they are ignored
localparam logic [2:0]  REG_SPARE_6 = 3'd6;
localparam logic [2:0]  REG_SPARE_7 = 3'd7;

typedef struct packed {
    logic level;
    logic busy;
    logic done;
} line_word_t;

typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_HIGH,
    SEQ_LOW,
    SEQ_GAP
} seq_phase_t;

// predicts the radio line level per tick and checks the result words against it
class pulse_line_scoreboard;
    logic [15:0] master_code;
    logic [13:0] short_high;
    logic [13:0] long_high;
    logic [13:0] low_len;
    logic [13:0] gap_len;
    logic [3:0]  pass_total;

    logic [47:0] frame;
    int unsigned bit_idx;
    logic [3:0]  passes_done;
    seq_phase_t  seq;
    logic [13:0] ticks_left;

    line_word_t  line_q[$];
    int unsigned n_fail;
    int unsigned n_words;
    int unsigned n_done;

    function new();
        master_code = 16'd25105;
        short_high  = 14'd295;
        long_high   = 14'd645;
        low_len     = 14'd285;
        gap_len     = 14'd9500;
        pass_total  = 4'd5;
        frame       = '0;
        bit_idx     = 0;
        passes_done = '0;
        seq         = SEQ_IDLE;
        ticks_left  = '0;
        n_fail      = 0;
        n_words     = 0;
        n_done      = 0;
    endfunction

    function logic [13:0] at_least_one(logic [13:0] v);
        return (v == 14'd0) ? 14'd1 : v;
    endfunction

    function logic [3:0] group_nibble(logic [2:0] grp);
        case (grp)
            3'd0:    return 4'hF;
            3'd1:    return 4'hE;
            3'd2:    return 4'hD;
            3'd3:    return 4'hC;
            3'd4:    return 4'hA;
            default: return 4'h9;
        endcase
    endfunction

    // 14 - 2*button, one less for the off code
    function logic [3:0] button_nibble(logic [2:0] btn, logic on);
        int v;
        v = 14 - 2 * int'(btn) - (on ? 0 : 1);
        return v[3:0];
    endfunction

    function void load_bit();
        seq        = SEQ_HIGH;
        ticks_left = frame[FRAME_BITS - 1 - bit_idx] ? at_least_one(short_high)
                                                     : at_least_one(long_high);
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            rfoc_pkg::REG_MASTER_CODE: master_code = val;
            rfoc_pkg::REG_SHORT_HIGH:  short_high  = val[13:0];
            rfoc_pkg::REG_LONG_HIGH:   long_high   = val[13:0];
            rfoc_pkg::REG_LOW:         low_len     = val[13:0];
            rfoc_pkg::REG_GAP:         gap_len     = val[13:0];
            rfoc_pkg::REG_REPEAT:      pass_total  = val[3:0];
            default: ;
        endcase
    endfunction

    // one accepted tick: advance the sequencer and queue the expected word
    function void note_tick(logic cmd, logic [2:0] grp, logic [2:0] btn, logic on);
        line_word_t w;
        logic [3:0] want;
        w = '0;
        if (seq == SEQ_IDLE && cmd && grp <= GROUP_LAST && btn <= BUTTON_LAST)
        begin
            frame = {FRAME_HEAD, master_code, group_nibble(grp), button_nibble(btn, on),
                     FRAME_TAIL};
            bit_idx     = 0;
            passes_done = '0;
            load_bit();
        end
        if (seq != SEQ_IDLE)
        begin
            want       = (pass_total == 4'd0) ? 4'd1 : pass_total;
            w.busy     = 1'b1;
            w.level    = (seq == SEQ_HIGH);
            ticks_left = ticks_left - 14'd1;
            if (ticks_left == 14'd0)
            begin
                case (seq)
                    SEQ_HIGH:
                    begin
                        seq        = SEQ_LOW;
                        ticks_left = at_least_one(low_len);
                    end
                    SEQ_LOW:
                    begin
                        if (bit_idx >= FRAME_BITS - 1)
                        begin
                            seq        = SEQ_GAP;
                            ticks_left = at_least_one(gap_len);
                        end
                        else
                        begin
                            bit_idx++;
                            load_bit();
                        end
                    end
                    default:
                    begin
                        passes_done = passes_done + 4'd1;
                        bit_idx     = 0;
                        if (passes_done >= want || passes_done == 4'd0)
                        begin
                            seq        = SEQ_IDLE;
                            ticks_left = '0;
                            w.done     = 1'b1;
                        end
                        else
                        begin
                            load_bit();
                        end
                    end
                endcase
            end
        end
        line_q.push_back(w);
    endfunction

    function bit seq_busy();
        return seq != SEQ_IDLE;
    endfunction

    function int pending();
        return line_q.size();
    endfunction

    task report(string msg);
        n_fail++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_word(logic level, logic busy, logic done);
        line_word_t w;
        n_words++;
        if (done)
        begin
            n_done++;
        end
        if (line_q.size() == 0)
        begin
            report($sformatf("word %0d arrived with nothing expected (level %b busy %b done %b)",
                             n_words, level, busy, done));
            return;
        end
        w = line_q.pop_front();
        if (level !== w.level)
        begin
            report($sformatf("word %0d rf_level %b, expected %b", n_words, level, w.level));
        end
        if (busy !== w.busy)
        begin
            report($sformatf("word %0d busy_res %b, expected %b", n_words, busy, w.busy));
        end
        if (done !== w.done)
        begin
            report($sformatf("word %0d done_res %b, expected %b", n_words, done, w.done));
        end
    endtask
endclass

module tb;

    // generous ceiling; the slowest legal run stays well below it
    localparam int LIMIT_CYCLES = 3000000;
    // long receiver hold-off so that the block backs up and drops s_axis_tready
    localparam int HOLD_CYCLES  = 200;

    logic clk = 1'b0;
    logic rst_n;

    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    // [2:0] group_letter, [5:3] button_number, [6] turn_on, [7] zero
    logic [rfoc_pkg::IN_TDATA_W-1:0]    s_axis_tdata;
    // [0] command
    logic                               s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    // [0] rf_level, [1] busy_res, [7:2] zero
    logic [rfoc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    // done_res
    logic                               m_axis_tlast;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [rfoc_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [rfoc_pkg::CFG_DATA_W-1:0]    cfg_data;

    pulse_line_scoreboard line_sb = new();

    // idling switch shared by both sides, and the one-off hold request
    bit          idle_en  = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned n_ticks  = 0;
    int unsigned n_cfg    = 0;
    int unsigned n_cycles = 0;

    rf_outlet_code_pulse_encoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // run ceiling
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: every accepted word goes straight to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            line_sb.check_word(m_axis_tdata[0], m_axis_tdata[1], m_axis_tlast);
        end
    end

    // receiver: random back-pressure per word, plus the long hold when asked
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_en ? $urandom_range(0, 15) : 0;
            if (hold_req)
            begin
                stall    = stall + HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
        end
    end

    // offer one tick word, wait for it to be taken, then tell the predictor
    task automatic send_tick(input logic cmd, input logic [2:0] grp, input logic [2:0] btn,
                             input logic on);
        int gap;
        gap = idle_en ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, on, btn, grp};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        line_sb.note_tick(cmd, grp, btn, on);
        n_ticks++;
    endtask

    // mostly valid requests with a sprinkle of out-of-range group and button codes
    task automatic send_random_tick();
        logic       cmd;
        logic [2:0] grp;
        logic [2:0] btn;
        cmd = ($urandom_range(0, 9) < 7);
        grp = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        btn = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        send_tick(cmd, grp, btn, 1'($urandom_range(0, 1)));
    endtask

    // keep ticking until the frame sequence is over; requests on these ticks are ignored
    task automatic run_out_sequence();
        while (line_sb.seq_busy())
        begin
            send_random_tick();
        end
    endtask

    // drop valid and let every expected word drain before touching registers
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (line_sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        line_sb.write_reg(idx, val);
        n_cfg++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(input logic [15:0] code, input logic [15:0] hi1,
                              input logic [15:0] hi0, input logic [15:0] lo,
                              input logic [15:0] gp, input logic [15:0] reps);
        set_reg(rfoc_pkg::REG_MASTER_CODE, code);
        set_reg(rfoc_pkg::REG_SHORT_HIGH, hi1);
        set_reg(rfoc_pkg::REG_LONG_HIGH, hi0);
        set_reg(rfoc_pkg::REG_LOW, lo);
        set_reg(rfoc_pkg::REG_GAP, gp);
        set_reg(rfoc_pkg::REG_REPEAT, reps);
    endtask

    task automatic send_frame(input logic [2:0] grp, input logic [2:0] btn, input logic on);
        send_tick(1'b1, grp, btn, on);
        run_out_sequence();
    endtask

    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: bad group or button codes must leave the block idle
        send_tick(1'b1, 3'd6, 3'd0, 1'b1);
        send_tick(1'b1, 3'd7, 3'd2, 1'b0);
        send_tick(1'b1, 3'd0, 3'd5, 1'b1);
        send_tick(1'b1, 3'd3, 3'd7, 1'b0);
        send_tick(1'b0, 3'd7, 3'd7, 1'b1);
        send_tick(1'b0, 3'd0, 3'd0, 1'b0);
        wait_quiet();

        // spare indexes must change nothing; master code stays at its reset value
        set_reg(REG_SPARE_6, 16'hFFFF);
        set_reg(REG_SPARE_7, 16'h0000);

        // zero durations behave as one tick, zero repeat as a single pass
        set_reg(rfoc_pkg::REG_SHORT_HIGH, 16'd0);
        set_reg(rfoc_pkg::REG_LONG_HIGH, 16'd0);
        set_reg(rfoc_pkg::REG_LOW, 16'd0);
        set_reg(rfoc_pkg::REG_GAP, 16'd0);
        set_reg(rfoc_pkg::REG_REPEAT, 16'd0);
        send_frame(3'd5, 3'd0, 1'b1);
        wait_quiet();

        // widest duration values written, only refused requests and plain ticks follow
        set_timing(16'hFFFF, 16'd16383, 16'd16383, 16'd16383, 16'd16383, 16'd15);
        send_tick(1'b1, 3'd6, 3'd4, 1'b1);
        send_tick(1'b1, 3'd1, 3'd6, 1'b0);
        send_tick(1'b0, 3'd2, 3'd3, 1'b1);
        wait_quiet();

        // random part: short random timings with one and zero bits kept apart,
        // two passes under a long hold, then a single pass flat out
        for (int chunk = 0; chunk < 2; chunk++)
        begin
            set_timing(16'($urandom), 16'($urandom_range(0, 1)), 16'($urandom_range(2, 3)),
                       16'($urandom_range(0, 1)), 16'($urandom_range(0, 2)),
                       16'(2 - chunk));
            if (chunk == 0)
            begin
                hold_req = 1'b1;
            end
            idle_en = (chunk == 0);
            for (int i = 0; i < 40; i++)
            begin
                send_random_tick();
            end
            run_out_sequence();
            wait_quiet();
        end
        idle_en = 1'b1;

        $display("covered %0d tick words, %0d result words, %0d completed frame sequences",
                 n_ticks, line_sb.n_words, line_sb.n_done);
        $display("%0d register writes incl. zero, widest and unmapped indexes", n_cfg);
        if (line_sb.n_fail == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
